// ----- sv/b64e_pkg.sv -----
// Shared types and constants for the streaming Base64 encoder.
// Holds the job record that passes from the front end to the character
// back end, the queue sizing and the sextet to ASCII mapping.
package b64e_pkg;

  localparam int QDepth = 2;
  localparam int QPtrW  = 1;
  localparam int QCntW  = 2;

  localparam logic [7:0] PadChar = 8'h3D;

  localparam logic [1:0] PhaseStart = 2'd0;
  localparam logic [1:0] PhaseOne   = 2'd1;
  localparam logic [1:0] PhaseTwo   = 2'd2;

  // One accepted byte becomes one job of one to four characters.
  typedef struct packed {
    logic [1:0]      last_idx;  // index of the final character in this job
    logic            fin;       // final character closes the message
    logic [3:0]      pad;       // per character: emit '=' instead of a sextet
    logic [3:0][5:0] sx;        // per character: 6-bit alphabet index
  } job_t;

  function automatic logic [7:0] sextet_to_ascii(input logic [5:0] idx);
    logic [7:0] c;
    begin
      if (idx < 6'd26) begin
        c = 8'h41 + {2'b00, idx};
      end else if (idx < 6'd52) begin
        c = 8'h61 + {2'b00, idx} - 8'd26;
      end else if (idx < 6'd62) begin
        c = 8'h30 + {2'b00, idx} - 8'd52;
      end else if (idx == 6'd62) begin
        c = 8'h2B;
      end else begin
        c = 8'h2F;
      end
      return c;
    end
  endfunction

endpackage

// ----- sv/b64e_front.sv -----
// Front end of the Base64 encoder: accepts raw bytes, tracks the position
// in the 3-byte group and turns each byte into a character job.
// Depends on b64e_pkg.
module b64e_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           take,       // a byte is accepted at this edge
  input  logic [7:0]     data_byte,
  input  logic           last_byte,
  output b64e_pkg::job_t job
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] left_r, left_nxt;

  always_comb begin
    job       = '0;
    phase_nxt = b64e_pkg::PhaseStart;
    left_nxt  = 4'd0;
    case (phase_r)
      b64e_pkg::PhaseOne: begin
        job.sx[0] = {left_r[1:0], data_byte[7:4]};
        if (last_byte) begin
          job.sx[1]    = {data_byte[3:0], 2'b00};
          job.pad[2]   = 1'b1;
          job.last_idx = 2'd2;
          job.fin      = 1'b1;
        end else begin
          phase_nxt = b64e_pkg::PhaseTwo;
          left_nxt  = data_byte[3:0];
        end
      end
      b64e_pkg::PhaseTwo: begin
        job.sx[0]    = {left_r, data_byte[7:6]};
        job.sx[1]    = data_byte[5:0];
        job.last_idx = 2'd1;
        job.fin      = last_byte;
      end
      default: begin
        // Start of a group; the unused phase code behaves the same way.
        job.sx[0] = data_byte[7:2];
        if (last_byte) begin
          job.sx[1]    = {data_byte[1:0], 4'b0000};
          job.pad[2]   = 1'b1;
          job.pad[3]   = 1'b1;
          job.last_idx = 2'd3;
          job.fin      = 1'b1;
        end else begin
          phase_nxt = b64e_pkg::PhaseOne;
          left_nxt  = {2'b00, data_byte[1:0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= b64e_pkg::PhaseStart;
      left_r  <= 4'd0;
    end else if (take) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// ----- sv/b64e_queue.sv -----
// Short job queue between the encoder front end and the character back end.
// Depends on b64e_pkg for the job record and the queue depth.
module b64e_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  b64e_pkg::job_t push_job,
  output logic           not_full,
  input  logic           pop,
  output logic           head_valid,
  output b64e_pkg::job_t head_job
);

  b64e_pkg::job_t             mem_r [b64e_pkg::QDepth];
  logic [b64e_pkg::QPtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [b64e_pkg::QCntW-1:0] cnt_r;
  logic                       do_push, do_pop;

  assign not_full   = (cnt_r != b64e_pkg::QCntW'(b64e_pkg::QDepth));
  assign head_valid = (cnt_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_push    = push && not_full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- sv/b64e_back.sv -----
// Back end of the Base64 encoder: walks the characters of the head job,
// maps each sextet to ASCII and holds it in the output register.
// Depends on b64e_pkg.
module b64e_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  b64e_pkg::job_t head_job,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,
  output logic           out_tlast
);

  logic       out_valid_r;
  logic [7:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       load, emit, at_end;

  assign load   = !out_valid_r || out_tready;
  assign emit   = load && head_valid;
  assign at_end = (idx_r == head_job.last_idx);
  assign pop    = emit && at_end;

  always_comb begin
    out_char_nxt = head_job.pad[idx_r] ? b64e_pkg::PadChar
                                       : b64e_pkg::sextet_to_ascii(head_job.sx[idx_r]);
    out_last_nxt = head_job.fin && at_end;
    idx_nxt      = at_end ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (head_valid) begin
        idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_char_r;
  assign out_tlast  = out_last_r;

  // An empty queue never leaves the walk in the middle of a job.
  a_idle_idx: assert property (@(posedge clk) disable iff (!rst_n)
    !head_valid |-> idx_r == 2'd0)
    else $error("character index nonzero with empty queue");

  // The walk never steps past the final character of the head job.
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> idx_r <= head_job.last_idx)
    else $error("character index beyond job length");

  // While the closing character of a message is held, the next job starts fresh.
  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> idx_r == 2'd0)
    else $error("final character shown mid-job");

endmodule

// ----- sv/base64_stream_encoder_unit.sv -----
// Top level of the streaming Base64 encoder (standard alphabet, padded).
// Depends on b64e_pkg, b64e_front, b64e_queue and b64e_back.
//
// Usage:
//   The input channel carries one raw message byte per beat; in_tlast marks
//   the final byte of a message. The output channel carries one ASCII
//   character per beat; out_tlast marks the final character of a message.
//   A message is encoded in 3-byte groups: bytes one and two of a group give
//   one character each, byte three gives two. A last byte closes a partial
//   group with zero fill and '=' padding, giving up to four characters.
//   A byte accepted by the front end is registered as a job in the queue;
//   its first character is then registered on the output when that side is free.
//   Throughput: the back end emits one character per cycle while the
//   receiver is ready, so a byte is taken every cycle while the queue has
//   room; a full group of three bytes gives four characters. The
//   two-entry job queue lets the front keep accepting while the back drains.
//   Reset (rst_n low, synchronous) empties the queue, drops any held
//   character and returns to the start of a group.
//   When the receiver stalls, the held character stays on the output and
//   the queue fills; in_tready drops once the queue is full.
module base64_stream_encoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] encoded_char
  output logic       out_tlast   // last_char
);

  b64e_pkg::job_t new_job, head_job;
  logic           q_not_full, head_valid, pop, take;

  // A byte is taken whenever the queue has room for its job.
  assign in_tready = q_not_full;
  assign take      = in_tvalid && q_not_full;

  b64e_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .job       (new_job)
  );

  b64e_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (take),
    .push_job   (new_job),
    .not_full   (q_not_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b64e_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for base64_stream_encoder_unit.
// Predicts every encoded character from the accepted input bytes and checks
// the output stream against it; depends on b64e_pkg and the encoder RTL.
`timescale 1ns / 100ps

module testbench;

  localparam string B64Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam int RandomBytes = 264;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } b64_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] data_byte
  logic       in_tlast = 1'b0;    // last_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] encoded_char
  logic       out_tlast;          // last_char

  // Encoder state as the predictor sees it.
  logic [1:0] enc_phase = b64e_pkg::PhaseStart;
  logic [3:0] enc_leftover = 4'h0;

  b64_char_t pending_chars[$];
  int        mismatches = 0;
  bit        idle_off = 1'b0;     // when set, neither side inserts gaps
  bit        rx_enable = 1'b0;

  base64_stream_encoder_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] b64_symbol(input logic [5:0] idx);
    return B64Alphabet[idx];
  endfunction

  function automatic void queue_char(input logic [7:0] ch, input logic fin);
    b64_char_t c;
    c.ch  = ch;
    c.fin = fin;
    pending_chars.push_back(c);
  endfunction

  // Expected characters for one accepted byte; updates the predicted state.
  function automatic void predict_encoding(input logic [7:0] b, input logic last);
    case (enc_phase)
      b64e_pkg::PhaseOne: begin
        queue_char(b64_symbol({enc_leftover[1:0], b[7:4]}), 1'b0);
        if (last) begin
          queue_char(b64_symbol({b[3:0], 2'b00}), 1'b0);
          queue_char(b64e_pkg::PadChar, 1'b1);
          enc_phase    = b64e_pkg::PhaseStart;
          enc_leftover = 4'h0;
        end else begin
          enc_phase    = b64e_pkg::PhaseTwo;
          enc_leftover = b[3:0];
        end
      end
      b64e_pkg::PhaseTwo: begin
        queue_char(b64_symbol({enc_leftover, b[7:6]}), 1'b0);
        queue_char(b64_symbol(b[5:0]), last);
        enc_phase    = b64e_pkg::PhaseStart;
        enc_leftover = 4'h0;
      end
      default: begin
        // The start of a group; the unused phase value would land here too.
        queue_char(b64_symbol(b[7:2]), 1'b0);
        if (last) begin
          queue_char(b64_symbol({b[1:0], 4'h0}), 1'b0);
          queue_char(b64e_pkg::PadChar, 1'b0);
          queue_char(b64e_pkg::PadChar, 1'b1);
          enc_phase    = b64e_pkg::PhaseStart;
          enc_leftover = 4'h0;
        end else begin
          enc_phase    = b64e_pkg::PhaseOne;
          enc_leftover = {2'b00, b[1:0]};
        end
      end
    endcase
  endfunction

  // Sends one byte beat. Called at a rising edge and returns at the edge
  // where the beat is taken, with in_tvalid still high.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int  gap;
    bit  taken;
    gap = idle_off ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    // Handshake signals are settled at the falling edge and hold until
    // the next rising edge, so sampling there is free of races.
    do begin
      @(negedge clk);
      taken = in_tready;
      if (taken) predict_encoding(b, last);
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  // Holds the sender back until every predicted character has come out.
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  task automatic test_single_byte_messages();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h4D, 1'b1);
  endtask

  task automatic test_two_byte_messages();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_three_byte_groups();
    // "Man" encodes to "TWFu".
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    // A message that runs across two full groups.
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hBE, 1'b1);
  endtask

  task automatic test_back_to_back();
    idle_off = 1'b1;
    for (int m = 0; m < 8; m++) send_message($urandom_range(1, 6));
    idle_off = 1'b0;
  endtask

  task automatic test_drain_pause();
    send_message(5);
    wait_for_drain();
    send_message(4);
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    int sent;
    int len;
    sent = 0;
    while (sent < RandomBytes) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 9);
      idle_off = ($urandom_range(0, 5) == 0);
      send_message(len);
      sent += len;
    end
    idle_off = 1'b0;
  endtask

  // Receiver: draws a stall before every character, then takes one beat
  // and compares it with the oldest predicted character.
  initial begin : result_checker
    int        stall;
    bit        got;
    logic [7:0] ch;
    logic      fin;
    b64_char_t want;
    wait (rx_enable);
    @(posedge clk);
    forever begin
      stall = idle_off ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        got = out_tvalid;
        ch  = out_tdata;
        fin = out_tlast;
        @(posedge clk);
      end while (!got);
      if (pending_chars.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected character beat: expected none, actual char %02h last %0b",
                 $realtime, ch, fin);
      end else begin
        want = pending_chars.pop_front();
        if (ch !== want.ch) begin
          mismatches++;
          $display("%0t: encoded_char mismatch: expected %02h, actual %02h",
                   $realtime, want.ch, ch);
        end
        if (fin !== want.fin) begin
          mismatches++;
          $display("%0t: last_char mismatch: expected %0b, actual %0b",
                   $realtime, want.fin, fin);
        end
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : main_sequence
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    rx_enable = 1'b1;
    @(posedge clk);
    test_single_byte_messages();
    test_two_byte_messages();
    test_three_byte_groups();
    test_back_to_back();
    test_drain_pause();
    test_random_traffic();
    wait_for_drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
